### src/tbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, constants and helpers for the TEA block cipher pipeline.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned ROUNDS = 32;
	// one pipeline stage per half round
	localparam int unsigned N_STAGES = 2 * ROUNDS;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t DELTA = 32'h9E3779B9;

	localparam word_t KEY0_RST = 32'hB0F6FE55;
	localparam word_t KEY1_RST = 32'h410BBF62;
	localparam word_t KEY2_RST = 32'hB47CB3C9;
	localparam word_t KEY3_RST = 32'h7B293E97;

	typedef enum logic [1:0] {
		REG_KEY0 = 2'd0,
		REG_KEY1 = 2'd1,
		REG_KEY2 = 2'd2,
		REG_KEY3 = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} op_t;

	typedef struct packed {
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
	} key_t;

	// n times delta, modulo 2^32
	function automatic word_t round_sum(input int unsigned n);
		logic [2*WORD_W-1:0] prod;
		prod = (2*WORD_W)'(n) * (2*WORD_W)'(DELTA);
		return prod[WORD_W-1:0];
	endfunction

	// sum used by encryption in half-round stage idx
	function automatic word_t enc_sum(input int unsigned idx);
		return round_sum(idx / 2 + 1);
	endfunction

	// sum used by decryption in half-round stage idx
	function automatic word_t dec_sum(input int unsigned idx);
		return round_sum(ROUNDS - idx / 2);
	endfunction

endpackage

### src/tbc_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_round
// One TEA half round: mixes one word into the other, adding for encryption
// and subtracting for decryption.
// ----------------------------------------------------------------------------
module tbc_round (
	input  logic           op,
	input  logic           even,
	input  tbc_pkg::word_t enc_sum,
	input  tbc_pkg::word_t dec_sum,
	input  tbc_pkg::key_t  key,
	input  tbc_pkg::word_t w0_in,
	input  tbc_pkg::word_t w1_in,
	output tbc_pkg::word_t w0_out,
	output tbc_pkg::word_t w1_out
);
	import tbc_pkg::*;

	logic  upd_first;
	word_t src;
	word_t tgt;
	word_t sum;
	word_t ka;
	word_t kb;
	word_t mix;
	word_t res;

	always_comb begin
		// encrypt updates the first word on even stages, decrypt on odd ones
		upd_first = even ^ (op == OP_DECRYPT);
		sum       = (op == OP_DECRYPT) ? dec_sum : enc_sum;
		src       = upd_first ? w1_in : w0_in;
		tgt       = upd_first ? w0_in : w1_in;
		ka        = upd_first ? key.k0 : key.k2;
		kb        = upd_first ? key.k1 : key.k3;
		mix       = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
		res       = (op == OP_DECRYPT) ? (tgt - mix) : (tgt + mix);
		w0_out    = upd_first ? res : w0_in;
		w1_out    = upd_first ? w1_in : res;
	end

endmodule

### src/tea_block_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// Pipelined 32-round TEA engine, one 64-bit block per cycle while out does not stall, runtime key.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+---------------------
//  in      | in_valid, in_ready, op, first_word,       | block and operation
//          | second_word                               |
//  out     | out_valid, out_ready, out_first_word,     | transformed block
//          | out_second_word                           |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | key word writes
//
// One half round per stage: 64 stages then an output register feed out;
// one block per cycle sustained while out does not stall.
// Reset clears all valid bits and loads the default key.
// A skid register behind the output register absorbs the block that arrives
// while out stalls; in_ready drops only while it is full and the whole
// pipeline then holds.
// ----------------------------------------------------------------------------
module tea_block_cipher_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  tbc_pkg::word_t     first_word,
	input  tbc_pkg::word_t     second_word,
	output logic               out_valid,
	input  logic               out_ready,
	output tbc_pkg::word_t     out_first_word,
	output tbc_pkg::word_t     out_second_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  tbc_pkg::reg_idx_t  cfg_index,
	input  tbc_pkg::word_t     cfg_data
);
	import tbc_pkg::*;

	key_t  key_q;

	logic  vld_s [N_STAGES];
	logic  op_s  [N_STAGES];
	word_t w0_s  [N_STAGES];
	word_t w1_s  [N_STAGES];

	logic  o_vld_q;
	word_t o_w0_q;
	word_t o_w1_q;
	logic  skid_vld_q;
	word_t skid_w0_q;
	word_t skid_w1_q;

	logic  en;
	logic  last_vld;
	logic  o_free;
	logic  load_o_last;
	logic  load_skid;
	logic  load_o_skid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k0 <= KEY0_RST;
			key_q.k1 <= KEY1_RST;
			key_q.k2 <= KEY2_RST;
			key_q.k3 <= KEY3_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY0: key_q.k0 <= cfg_data;
				REG_KEY1: key_q.k1 <= cfg_data;
				REG_KEY2: key_q.k2 <= cfg_data;
				REG_KEY3: key_q.k3 <= cfg_data;
				default: ;
			endcase
		end
	end

	// the whole pipeline advances together unless the skid holds a block
	assign en       = !skid_vld_q;
	assign in_ready = en;

	for (genvar i = 0; i < N_STAGES; i++) begin : g_stage
		logic  src_vld;
		logic  src_op;
		word_t src_w0;
		word_t src_w1;
		word_t nxt_w0;
		word_t nxt_w1;

		if (i == 0) begin : g_head
			assign src_vld = in_valid;
			assign src_op  = op;
			assign src_w0  = first_word;
			assign src_w1  = second_word;
		end else begin : g_body
			assign src_vld = vld_s[i-1];
			assign src_op  = op_s[i-1];
			assign src_w0  = w0_s[i-1];
			assign src_w1  = w1_s[i-1];
		end

		tbc_round u_round (
			.op      (src_op),
			.even    (i % 2 == 0),
			.enc_sum (enc_sum(i)),
			.dec_sum (dec_sum(i)),
			.key     (key_q),
			.w0_in   (src_w0),
			.w1_in   (src_w1),
			.w0_out  (nxt_w0),
			.w1_out  (nxt_w1)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en && src_vld) begin
				op_s[i] <= src_op;
				w0_s[i] <= nxt_w0;
				w1_s[i] <= nxt_w1;
			end
		end
	end

	assign last_vld    = vld_s[N_STAGES-1];
	assign o_free      = !o_vld_q || out_ready;
	assign load_o_last = en && last_vld && o_free;
	assign load_skid   = en && last_vld && !o_free;
	assign load_o_skid = !en && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_vld_q    <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (load_o_last || load_o_skid) begin
				o_vld_q <= 1'b1;
			end else if (out_ready) begin
				o_vld_q <= 1'b0;
			end
			if (load_skid) begin
				skid_vld_q <= 1'b1;
			end else if (load_o_skid) begin
				skid_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_o_last) begin
			o_w0_q <= w0_s[N_STAGES-1];
			o_w1_q <= w1_s[N_STAGES-1];
		end else if (load_o_skid) begin
			o_w0_q <= skid_w0_q;
			o_w1_q <= skid_w1_q;
		end
		if (load_skid) begin
			skid_w0_q <= w0_s[N_STAGES-1];
			skid_w1_q <= w1_s[N_STAGES-1];
		end
	end

	assign out_valid       = o_vld_q;
	assign out_first_word  = o_w0_q;
	assign out_second_word = o_w1_q;

endmodule

### src/tbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbc_checker
// Port-level checks for the TEA block cipher pipeline, bound to the top.
// ----------------------------------------------------------------------------
module tbc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_ready,
	input logic           out_valid,
	input logic           out_ready,
	input tbc_pkg::word_t out_first_word,
	input tbc_pkg::word_t out_second_word,
	input logic           cfg_ready
);
	import tbc_pkg::*;

	// a stalled result transaction stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_first_word) && $stable(out_second_word))
		else $error("out payload changed while stalled");

	// input back-pressure only happens behind a pending result
	a_bp_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("in_ready low with no result pending");

	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("in_ready fell without an output stall");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

endmodule

bind tea_block_cipher_top tbc_checker u_tbc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.out_first_word  (out_first_word),
	.out_second_word (out_second_word),
	.cfg_ready       (cfg_ready)
);
